@@ rtl/nbb_pkg.sv @@
// Shared types and constants of the 3x3 neighbour blur.
// No dependencies; used by the channel interfaces and the top level.
package nbb_pkg;

	localparam int CHAN_W     = 8;
	localparam int COLUMN_W   = 11;
	localparam int ROW_W      = 12;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 13;
	localparam int FW_W       = 12;
	localparam int FH_W       = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 4'd0,
		REG_FRAME_HEIGHT = 4'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} pix_t;

	// Sum of eight channel values, each truncated to eighths first.
	function automatic logic [CHAN_W-1:0] chan_blur(input logic [8*CHAN_W-1:0] v);
		logic [CHAN_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < 8; k++) begin
			acc = acc + CHAN_W'(v[k*CHAN_W +: CHAN_W] >> 3);
		end
		return acc;
	endfunction

	function automatic pix_t pix_blur(input pix_t n0, input pix_t n1, input pix_t n2,
		input pix_t n3, input pix_t n4, input pix_t n5, input pix_t n6, input pix_t n7);
		pix_t res;
		res.r = chan_blur({n0.r, n1.r, n2.r, n3.r, n4.r, n5.r, n6.r, n7.r});
		res.g = chan_blur({n0.g, n1.g, n2.g, n3.g, n4.g, n5.g, n6.g, n7.g});
		res.b = chan_blur({n0.b, n1.b, n2.b, n3.b, n4.b, n5.b, n6.b, n7.b});
		return res;
	endfunction

endpackage

@@ rtl/nbb_ifs.sv @@
// Channel interfaces of the 3x3 neighbour blur: pixel in, result out, config.
// Depends on nbb_pkg.
interface nbb_pix_if import nbb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red_in;
	logic [CHAN_W-1:0] green_in;
	logic [CHAN_W-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		output ready);
endinterface

interface nbb_res_if import nbb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CHAN_W-1:0]   red_out;
	logic [CHAN_W-1:0]   green_out;
	logic [CHAN_W-1:0]   blue_out;
	logic [COLUMN_W-1:0] out_column;
	logic [ROW_W-1:0]    out_row;
	logic                run_last;
	logic                frame_done;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output out_column, output out_row, output run_last, output frame_done,
		input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input out_column, input out_row, input run_last, input frame_done,
		output ready);
endinterface

interface nbb_cfg_if import nbb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/neighbour_box_blur_3x3_top.sv @@
// 3x3 neighbour blur of a raster RGB stream: two line memories, a two-column
// window, one work stage and a result register. Depends on nbb_pkg, nbb_ifs.
//
//   channel | dir | word                                      | accepted when
//   pix_in  | in  | red_in, green_in, blue_in                 | valid & ready
//   res_out | out | rgb, out_column, out_row, run_last, done  | valid & ready
//   cfg     | in  | index, data (frame_width / frame_height)  | valid & ready
//
// One pixel per clock while the result side keeps up; a pixel that yields k results holds
// the work stage until all k are loaded, since the result register takes one word a clock
// when res_out is ready (extra words come at each row end and past column 0 of the last row).
// A pixel's result words pass from the work stage through the result register to res_out.
// Reset clears counters and valid flags and sets the size to its reset value;
// line memories are not cleared. A stalled result register holds the work stage and input.
module neighbour_box_blur_3x3_top import nbb_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic clk,
	input  logic arst_n,
	nbb_pix_if.sink   pix_in,
	nbb_res_if.source res_out,
	nbb_cfg_if.sink   cfg
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int W_RST = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
	localparam logic [CW-1:0] W_RST_LAST = CW'(W_RST - 1);
	localparam logic [CW-1:0] W_MAX_LAST = CW'(MAX_WIDTH - 1);
	localparam logic [RW-1:0] H_MAX_LAST = RW'(MAX_HEIGHT - 1);

	// line memories
	pix_t prev_mem [MAX_WIDTH];
	pix_t sec_mem  [MAX_WIDTH];

	logic [CW-1:0] wlast_q;
	logic [RW-1:0] hlast_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic          valid_s1;
	pix_t          cur_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          byp_s1;
	pix_t          bp1_s1;
	pix_t          bp2_s1;
	pix_t          rd1_q;
	pix_t          rd2_q;
	pix_t          win_q [6];
	logic [2:0]    sent_q;

	logic          out_valid_q;
	pix_t          out_pix_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;
	logic          out_last_q;
	logic          out_done_q;

	logic          in_fire;
	logic          cfg_fire;
	logic          s1_retire;
	logic          out_load;
	pix_t          up1_e;
	pix_t          up2_e;
	logic [2:0]    flags;
	logic [2:0]    pend;
	logic [2:0]    pick;
	pix_t          pick_pix;
	logic [CW-1:0] pick_col;
	logic [RW-1:0] pick_row;
	logic          pick_done;
	logic          pick_last;
	pix_t          delayed_pix;
	logic [CW-1:0] wlast_nxt;
	logic [RW-1:0] hlast_nxt;
	logic [FW_W-1:0] fw;
	logic [FH_W-1:0] fh;

	assign cfg_fire  = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;
	assign pix_in.ready = !valid_s1 || s1_retire;
	assign in_fire   = pix_in.valid && pix_in.ready;

	// effective last column and row of a written size
	assign fw = cfg.data[FW_W-1:0];
	assign fh = cfg.data[FH_W-1:0];
	always_comb begin
		if (fw == '0) begin
			wlast_nxt = '0;
		end else if (32'(fw) > MAX_WIDTH) begin
			wlast_nxt = W_MAX_LAST;
		end else begin
			wlast_nxt = CW'(fw - FW_W'(1));
		end
		if (fh == '0) begin
			hlast_nxt = '0;
		end else if (32'(fh) > MAX_HEIGHT) begin
			hlast_nxt = H_MAX_LAST;
		end else begin
			hlast_nxt = RW'(fh - FH_W'(1));
		end
	end

	// take the line memory forward when the write to the same column retires now
	assign up1_e = byp_s1 ? bp1_s1 : rd1_q;
	assign up2_e = byp_s1 ? bp2_s1 : rd2_q;

	always_comb begin
		if (row_s1 >= RW'(2) && col_s1 >= CW'(2)) begin
			delayed_pix = pix_blur(up2_e, up1_e, cur_s1, win_q[0], win_q[2],
				win_q[3], win_q[4], win_q[5]);
		end else begin
			delayed_pix = win_q[1];
		end
	end

	// bit 0: delayed pixel, bit 1: row end of previous row, bit 2: last row
	assign flags[0] = (row_s1 != '0) && (col_s1 != '0);
	assign flags[1] = (row_s1 != '0) && (col_s1 == wlast_q);
	assign flags[2] = (row_s1 == hlast_q);
	assign pend     = valid_s1 ? (flags & ~sent_q) : 3'b000;

	always_comb begin
		pick      = 3'b000;
		pick_pix  = cur_s1;
		pick_col  = col_s1;
		pick_row  = row_s1;
		pick_done = 1'b0;
		if (pend[0]) begin
			pick     = 3'b001;
			pick_pix = delayed_pix;
			pick_col = col_s1 - CW'(1);
			pick_row = row_s1 - RW'(1);
		end else if (pend[1]) begin
			pick     = 3'b010;
			pick_pix = up1_e;
			pick_row = row_s1 - RW'(1);
		end else if (pend[2]) begin
			pick      = 3'b100;
			pick_done = (col_s1 == wlast_q);
		end
		pick_last = ((pend & ~pick) == 3'b000);
	end

	assign out_load  = (pend != 3'b000) && (!out_valid_q || res_out.ready);
	assign s1_retire = valid_s1 && ((pend == 3'b000) || (out_load && pick_last));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q     <= W_RST_LAST;
			hlast_q     <= '0;
			col_q       <= '0;
			row_q       <= '0;
			valid_s1    <= 1'b0;
			sent_q      <= 3'b000;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				if (cfg.index == REG_FRAME_WIDTH) begin
					wlast_q <= wlast_nxt;
					col_q   <= '0;
					row_q   <= '0;
				end else if (cfg.index == REG_FRAME_HEIGHT) begin
					hlast_q <= hlast_nxt;
					col_q   <= '0;
					row_q   <= '0;
				end
			end else if (in_fire) begin
				if (col_q == wlast_q) begin
					col_q <= '0;
					row_q <= (row_q == hlast_q) ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end

			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_retire) begin
				valid_s1 <= 1'b0;
			end

			if (s1_retire) begin
				sent_q <= 3'b000;
			end else if (out_load) begin
				sent_q <= sent_q | pick;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// work stage payload and line memory reads
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cur_s1 <= '{r: pix_in.red_in, g: pix_in.green_in, b: pix_in.blue_in};
			col_s1 <= col_q;
			row_s1 <= row_q;
			rd1_q  <= prev_mem[col_q];
			rd2_q  <= sec_mem[col_q];
			byp_s1 <= s1_retire && (col_s1 == col_q);
			bp1_s1 <= cur_s1;
			bp2_s1 <= up1_e;
		end
	end

	// line memory writes and window shift as the pixel leaves the work stage
	always_ff @(posedge clk) begin
		if (s1_retire) begin
			prev_mem[col_s1] <= cur_s1;
			sec_mem[col_s1]  <= up1_e;
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= up2_e;
			win_q[1] <= up1_e;
			win_q[2] <= cur_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pix_q  <= pick_pix;
			out_col_q  <= pick_col;
			out_row_q  <= pick_row;
			out_last_q <= pick_last;
			out_done_q <= pick_done;
		end
	end

	assign res_out.valid      = out_valid_q;
	assign res_out.red_out    = out_pix_q.r;
	assign res_out.green_out  = out_pix_q.g;
	assign res_out.blue_out   = out_pix_q.b;
	assign res_out.out_column = COLUMN_W'(out_col_q);
	assign res_out.out_row    = ROW_W'(out_row_q);
	assign res_out.run_last   = out_last_q;
	assign res_out.frame_done = out_done_q;

endmodule

@@ dv/tb.sv @@
// Self-checking bench for neighbour_box_blur_3x3_top: random RGB frames of many sizes,
// scored word by word against a built-in blur predictor.
// Depends on rtl/nbb_pkg.sv, rtl/nbb_ifs.sv and the top level.
`timescale 1ns / 100ps

module tb;
	import nbb_pkg::*;

	localparam int MAX_W        = 2048;
	localparam int MAX_H        = 4096;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int RAND_ITEMS   = 360;
	localparam int TAIL_ITEMS   = 32;
	localparam int PRINT_CAP    = 50;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = '1;

	typedef struct packed {
		pix_t                px;
		logic [COLUMN_W-1:0] col;
		logic [ROW_W-1:0]    row;
		logic                last;
		logic                done;
	} blur_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #4 clk = ~clk;

	nbb_pix_if pix_if ();
	nbb_res_if res_if ();
	nbb_cfg_if cfg_if ();

	// bench-side drivers, known from time zero
	logic                  pix_valid = 1'b0;
	pix_t                  pix_word  = '0;
	logic                  rx_ready  = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	assign pix_if.valid    = pix_valid;
	assign pix_if.red_in   = pix_word.r;
	assign pix_if.green_in = pix_word.g;
	assign pix_if.blue_in  = pix_word.b;
	assign res_if.ready    = rx_ready;
	assign cfg_if.valid    = cfg_valid;
	assign cfg_if.index    = cfg_index;
	assign cfg_if.data     = cfg_data;

	neighbour_box_blur_3x3_top #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_if),
		.res_out (res_if),
		.cfg     (cfg_if)
	);

	// predictor state
	logic [FW_W-1:0] width_reg  = FW_W'(MAX_W);
	logic [FH_W-1:0] height_reg = FH_W'(1);
	pix_t            line_above  [MAX_W];
	pix_t            line_above2 [MAX_W];
	pix_t            win_cols    [6];
	int unsigned     next_col = 0;
	int unsigned     next_row = 0;

	pix_t        pixel_q [$];
	blur_word_t  blur_q  [$];
	int unsigned errors     = 0;
	bit          calm       = 1'b0;
	int unsigned holds_req  = 0;
	int unsigned holds_done = 0;
	int unsigned hold_left  = 0;
	int unsigned tx_wait    = 0;
	int unsigned rx_wait    = 0;
	int unsigned rx_gap;

	function automatic int unsigned eff_size(input int unsigned v, input int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	function automatic int unsigned idle_draw();
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	function automatic pix_t pixel_rand();
		pix_t p;
		p = pix_t'($urandom);
		// bias channels toward the rails
		case ($urandom_range(0, 5))
			0: p.r = '0;
			1: p.g = '1;
			2: p.b = '0;
			3: p.r = '1;
			default: ;
		endcase
		return p;
	endfunction

	// each neighbour drops to eighths before the add; the centre does not take part
	function automatic pix_t neighbour_mean(input pix_t [7:0] nb);
		pix_t acc;
		acc = '0;
		for (int k = 0; k < 8; k++) begin
			acc.r = acc.r + (nb[k].r >> 3);
			acc.g = acc.g + (nb[k].g >> 3);
			acc.b = acc.b + (nb[k].b >> 3);
		end
		return acc;
	endfunction

	task automatic predict_pixel(input pix_t cur);
		int unsigned w, h, i, j, n;
		pix_t        up1, up2, px;
		blur_word_t  res [3];
		w = eff_size(32'(width_reg), MAX_W);
		h = eff_size(32'(height_reg), MAX_H);
		i = (next_row >= h) ? h - 1 : next_row;
		j = (next_col >= w) ? w - 1 : next_col;
		up1 = line_above[j];
		up2 = line_above2[j];
		n = 0;
		// delayed pixel, one row up and one column left
		if (i >= 1 && j >= 1) begin
			if (i >= 2 && j >= 2)
				px = neighbour_mean({up2, up1, cur, win_cols[0], win_cols[2],
					win_cols[3], win_cols[4], win_cols[5]});
			else
				px = win_cols[1];
			res[n] = '{px, COLUMN_W'(j - 1), ROW_W'(i - 1), 1'b0, 1'b0};
			n++;
		end
		// right border of the row above
		if (i >= 1 && j == w - 1) begin
			res[n] = '{up1, COLUMN_W'(j), ROW_W'(i - 1), 1'b0, 1'b0};
			n++;
		end
		// bottom row goes straight through
		if (i == h - 1) begin
			res[n] = '{cur, COLUMN_W'(j), ROW_W'(i), 1'b0, (j == w - 1)};
			n++;
		end
		if (n > 0)
			res[n - 1].last = 1'b1;
		for (int k = 0; k < n; k++)
			blur_q.push_back(res[k]);
		win_cols[3] = win_cols[0];
		win_cols[4] = win_cols[1];
		win_cols[5] = win_cols[2];
		win_cols[0] = up2;
		win_cols[1] = up1;
		win_cols[2] = cur;
		line_above2[j] = up1;
		line_above[j]  = cur;
		j++;
		if (j >= w) begin
			j = 0;
			i++;
			if (i >= h)
				i = 0;
		end
		next_col = j;
		next_row = i;
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		if (idx == REG_FRAME_WIDTH) begin
			width_reg = val[FW_W-1:0];
		end else if (idx == REG_FRAME_HEIGHT) begin
			height_reg = val[FH_W-1:0];
		end else begin
			return;
		end
		// any mapped write restarts the frame
		next_col = 0;
		next_row = 0;
	endtask

	task automatic report(input string msg);
		if (errors < PRINT_CAP)
			$display("MISMATCH: %s", msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want, input blur_word_t ref_word);
		if (got !== want)
			report($sformatf("%s got %0d want %0d at row %0d col %0d", name, got, want,
				ref_word.row, ref_word.col));
	endtask

	task automatic check_word();
		blur_word_t want;
		if (blur_q.size() == 0) begin
			report($sformatf("unexpected word row %0d col %0d", res_if.out_row,
				res_if.out_column));
			return;
		end
		want = blur_q.pop_front();
		check_field("red", 16'(res_if.red_out), 16'(want.px.r), want);
		check_field("green", 16'(res_if.green_out), 16'(want.px.g), want);
		check_field("blue", 16'(res_if.blue_out), 16'(want.px.b), want);
		check_field("column", 16'(res_if.out_column), 16'(want.col), want);
		check_field("row", 16'(res_if.out_row), 16'(want.row), want);
		check_field("run_last", 16'(res_if.run_last), 16'(want.last), want);
		check_field("frame_done", 16'(res_if.frame_done), 16'(want.done), want);
	endtask

	// pixel driver: one gap per word, drawn when the word is offered
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			tx_wait   <= 0;
		end else begin
			if (pix_valid && pix_if.ready)
				predict_pixel(pix_word);
			if (!pix_valid || pix_if.ready) begin
				if (tx_wait != 0) begin
					pix_valid <= 1'b0;
					tx_wait   <= tx_wait - 1;
				end else if (pixel_q.size() != 0) begin
					pix_valid <= 1'b1;
					pix_word  <= pixel_q.pop_front();
					tx_wait   <= idle_draw();
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: scores each word, then idles for a drawn gap; also holds ready low for each requested long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ready   <= 1'b0;
			rx_wait    <= 0;
			hold_left  <= 0;
		end else begin
			rx_gap = rx_wait;
			if (res_if.valid && rx_ready) begin
				check_word();
				rx_gap = idle_draw();
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rx_ready  <= 1'b0;
			end else if (holds_done != holds_req) begin
				hold_left  <= LONG_HOLD;
				holds_done <= holds_done + 1;
				rx_ready   <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap   = rx_gap - 1;
				rx_ready <= 1'b0;
			end else begin
				rx_ready <= 1'b1;
			end
			rx_wait <= rx_gap;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_valid <= 1'b0;
		apply_reg(idx, val);
	endtask

	// wait until every pixel is taken and every word is back, then let the pipe settle
	task automatic drain();
		do @(posedge clk); while (pixel_q.size() != 0 || pix_valid || blur_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_random(input int unsigned n);
		for (int unsigned k = 0; k < n; k++)
			pixel_q.push_back(pixel_rand());
	endtask

	task automatic write_unmapped();
		write_reg(CFG_IDX_W'($urandom_range(REG_FRAME_HEIGHT + 1, REG_LAST_INDEX)),
			CFG_DATA_W'($urandom));
	endtask

	initial begin : stim
		int unsigned w, h, n, half, phase, rand_items;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size: one row, every pixel passes straight through
		pixel_q.push_back('{8'h00, 8'h00, 8'h00});
		pixel_q.push_back('{8'hFF, 8'hFF, 8'hFF});
		pixel_q.push_back('{8'hA5, 8'h5A, 8'h01});
		drain();

		// 3x3 frame: bright ring around a dark centre gives the largest blur sum
		write_reg(REG_FRAME_WIDTH, 13'd3);
		write_reg(REG_FRAME_HEIGHT, 13'd3);
		for (int k = 0; k < 9; k++)
			pixel_q.push_back((k == 4) ? pix_t'('0) : pix_t'('1));
		drain();

		// zero sizes act as one; bit 12 of the width data falls off
		write_reg(REG_FRAME_WIDTH, 13'h1000);
		write_reg(REG_FRAME_HEIGHT, 13'd0);
		write_unmapped();
		push_random(2);
		drain();

		// fill the block while the result side holds off
		calm = 1'b1;
		write_reg(REG_FRAME_WIDTH, 13'd7);
		write_reg(REG_FRAME_HEIGHT, 13'd5);
		push_random(35);
		holds_req++;
		drain();
		calm = 1'b0;
		// items sent so far
		rand_items = 3 + 9 + 2 + 35;

		phase = 0;
		while (rand_items < RAND_ITEMS - TAIL_ITEMS) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
			case ($urandom_range(0, 3))
				0: write_reg(REG_FRAME_WIDTH, {1'($urandom), FW_W'(w)});
				1: write_reg(REG_FRAME_HEIGHT, FH_W'(h));
				2: begin
					write_reg(REG_FRAME_HEIGHT, FH_W'(h));
					write_reg(REG_FRAME_WIDTH, {1'($urandom), FW_W'(w)});
				end
				default: begin
					write_reg(REG_FRAME_WIDTH, {1'($urandom), FW_W'(w)});
					write_reg(REG_FRAME_HEIGHT, FH_W'(h));
				end
			endcase
			calm = ($urandom_range(0, 4) == 0);
			n = eff_size(32'(width_reg), MAX_W) * eff_size(32'(height_reg), MAX_H);
			// mostly whole frames, sometimes a frame cut short
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, n);
			else
				n = n * $urandom_range(1, 2);
			// keep the run near its item budget
			if (n > RAND_ITEMS - TAIL_ITEMS - rand_items)
				n = RAND_ITEMS - TAIL_ITEMS - rand_items;
			if (phase == 0 || $urandom_range(0, 3) == 0) begin
				// pause mid-frame until the block is empty, then poke a dead index
				half = n / 2;
				push_random(half);
				drain();
				write_unmapped();
				push_random(n - half);
			end else begin
				push_random(n);
			end
			rand_items += n;
			drain();
			phase++;
		end

		// largest sizes on frames cut short, run without idling
		calm = 1'b1;
		write_reg(REG_FRAME_WIDTH, '1);
		write_reg(REG_FRAME_HEIGHT, 13'd1);
		push_random(TAIL_ITEMS / 2);
		drain();
		write_reg(REG_FRAME_WIDTH, 13'd1);
		write_reg(REG_FRAME_HEIGHT, '1);
		push_random(TAIL_ITEMS / 2);
		drain();
		calm = 1'b0;

		repeat (4 * DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/nbb_pkg.sv
rtl/nbb_ifs.sv
rtl/neighbour_box_blur_3x3_top.sv
dv/tb.sv
